// ===== rtl/temp_pressure_compensation_macros.svh =====
// ---------------------------------------------------------------------------
// temp_pressure_compensation_macros.svh
// assertion macros shared by the compensation checker
// ---------------------------------------------------------------------------
`ifndef TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// implication checked on every clock edge outside reset
`define TPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// invariant checked on every clock edge outside reset
`define TPC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ===== rtl/tpc_pkg.sv =====
// ---------------------------------------------------------------------------
// tpc_pkg
// constants and arithmetic helpers for the compensation pipeline
// ---------------------------------------------------------------------------
package tpc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_COEFFS  = 2'd0;
  localparam logic [1:0] REG_PRESS_WIDE   = 2'd1;
  localparam logic [1:0] REG_PRESS_NARROW = 2'd2;

  // compensation constants
  localparam logic signed [31:0] PRESS_OFFSET = 32'sd64000;
  localparam logic signed [31:0] PRESS_FULL   = 32'sd1048576;
  localparam logic signed [31:0] PRESS_SCALE  = 32'sd3125;
  localparam logic signed [31:0] PRESS_OVF    = 32'sd1073741824;
  localparam logic signed [31:0] P1_BIAS      = 32'sd32768;
  localparam logic signed [31:0] PRESS_MAX    = 32'sd262143;

  // divider depth and total latency from request to result strobe
  localparam int DIV_STAGES = 32;
  localparam int LATENCY    = 49;

  // low 32 bits of a signed product
  function automatic logic signed [31:0] mul32(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y);
    return p[31:0];
  endfunction

  // one restoring division step: returns {remainder, shifted dividend/quotient}
  function automatic logic [48:0] div_step(input logic [16:0] rem,
                                           input logic [31:0] num,
                                           input logic [16:0] dm);
    logic [17:0] rs;
    logic [17:0] df;
    rs = {rem, num[31]};
    df = rs - {1'b0, dm};
    if (rs >= {1'b0, dm}) begin
      return {df[16:0], num[30:0], 1'b1};
    end
    return {rs[16:0], num[30:0], 1'b0};
  endfunction

endpackage

// ===== rtl/temp_pressure_compensation.sv =====
// done marks the result of each accepted request on temp_centi and pressure_pa
// throughput: one request per cycle; busy stays low, the pipeline never stalls
// the 32-stage restoring divider (one quotient bit per stage) sets the depth
// reset: rst synchronous, clears the stage valid bits and the coefficient
// registers; results already in flight are dropped
// ---------------------------------------------------------------------------
// temp_pressure_compensation
// integer temperature and pressure compensation of raw converter readings
// ---------------------------------------------------------------------------
module temp_pressure_compensation
  import tpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [63:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        temp_raw,
  input  logic [19:0]        press_raw,
  output logic               done,
  output logic signed [15:0] temp_centi,
  output logic [17:0]        pressure_pa,
  output logic               div_fault
);

  // coefficient registers
  logic [39:0] temp_coeffs;
  logic [63:0] press_coeffs_wide;
  logic [63:0] press_coeffs_narrow;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs         <= '0;
      press_coeffs_wide   <= '0;
      press_coeffs_narrow <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TEMP_COEFFS:  temp_coeffs         <= cfg_wdata[39:0];
        REG_PRESS_WIDE:   press_coeffs_wide   <= cfg_wdata;
        REG_PRESS_NARROW: press_coeffs_narrow <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, p2, p4, p5, p8, p9;
  logic signed [7:0]  t3, p3, p6, p7;
  logic [7:0]         p10;

  assign t1  = temp_coeffs[15:0];
  assign t2  = temp_coeffs[31:16];
  assign t3  = temp_coeffs[39:32];
  assign p1  = press_coeffs_wide[15:0];
  assign p2  = press_coeffs_wide[31:16];
  assign p4  = press_coeffs_wide[47:32];
  assign p5  = press_coeffs_wide[63:48];
  assign p3  = press_coeffs_narrow[7:0];
  assign p6  = press_coeffs_narrow[15:8];
  assign p7  = press_coeffs_narrow[23:16];
  assign p8  = press_coeffs_narrow[39:24];
  assign p9  = press_coeffs_narrow[55:40];
  assign p10 = press_coeffs_narrow[63:56];

  assign busy = 1'b0;

  // stage valid bits, vld[n] belongs to stage n+1
  logic [LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  assign done = vld[LATENCY-1];

  // raw pressure delay line up to stage 8
  logic [19:0] pl [0:7];

  always_ff @(posedge clk) begin
    pl[0] <= press_raw;
    for (int k = 1; k < 8; k++) begin
      pl[k] <= pl[k-1];
    end
  end

  // temperature stages 1..4: fine temperature
  logic signed [17:0] a_s1;
  logic signed [16:0] ah_s1;
  logic signed [33:0] m1_s2, sq_s2;
  logic signed [22:0] b_s3;
  logic signed [29:0] m2_s3;
  logic signed [31:0] tfine_s4;

  assign ah_s1 = a_s1[17:1];

  always_ff @(posedge clk) begin
    a_s1     <= $signed({1'b0, temp_raw[19:3]}) - $signed({1'b0, t1, 1'b0});
    m1_s2    <= 34'(a_s1) * 34'(t2);
    sq_s2    <= 34'(ah_s1) * 34'(ah_s1);
    b_s3     <= m1_s2[33:11];
    m2_s3    <= 30'($signed({1'b0, sq_s2[32:12]})) * 30'(t3);
    tfine_s4 <= 32'(b_s3) + 32'(m2_s3 >>> 10);
  end

  // stage 5: temperature result and pressure offset
  logic signed [34:0] t5;
  logic signed [26:0] ts;
  logic signed [15:0] temp_sat;
  logic signed [15:0] tl [0:LATENCY-5];
  logic signed [31:0] pa_s5;

  always_comb begin
    t5 = 35'(tfine_s4) * 35'sd5 + 35'sd128;
    ts = t5[34:8];
    if (ts > 27'sd32767) begin
      temp_sat = 16'sh7fff;
    end else if (ts < -27'sd32768) begin
      temp_sat = 16'sh8000;
    end else begin
      temp_sat = ts[15:0];
    end
  end

  always_ff @(posedge clk) begin
    tl[0] <= temp_sat;
    for (int k = 1; k <= LATENCY - 5; k++) begin
      tl[k] <= tl[k-1];
    end
    pa_s5 <= (tfine_s4 >>> 1) - PRESS_OFFSET;
  end

  assign temp_centi = tl[LATENCY-5];

  // stages 6..10: pressure terms and divisor
  logic signed [31:0] sq_s6, ma5_s6, mp2a_s6;
  logic signed [31:0] tb1_s7, ta1_s7, a5x2_s7, p2a_s7;
  logic signed [31:0] bb, bb2, aa;
  logic signed [31:0] b_s8, a18_s8;
  logic signed [31:0] m_s9, pc_s9;
  logic signed [16:0] dv_s10;
  logic signed [31:0] pcm_s10;

  always_comb begin
    bb  = (tb1_s7 >>> 2) + a5x2_s7;
    bb2 = (bb >>> 2) + $signed({p4, 16'h0000});
    aa  = (ta1_s7 >>> 3) + (p2a_s7 >>> 1);
  end

  always_ff @(posedge clk) begin
    sq_s6   <= mul32(pa_s5 >>> 2, pa_s5 >>> 2);
    ma5_s6  <= mul32(pa_s5, 32'(p5));
    mp2a_s6 <= mul32(32'(p2), pa_s5);
    tb1_s7  <= mul32(sq_s6 >>> 11, 32'(p6));
    ta1_s7  <= mul32(sq_s6 >>> 13, 32'(p3) <<< 5);
    a5x2_s7 <= ma5_s6 <<< 1;
    p2a_s7  <= mp2a_s6;
    b_s8    <= bb2;
    a18_s8  <= aa >>> 18;
    m_s9    <= mul32(P1_BIAS + a18_s8, $signed({16'h0000, p1}));
    pc_s9   <= (PRESS_FULL - $signed({12'h000, pl[7]})) - (b_s8 >>> 12);
    dv_s10  <= m_s9[31:15];
    pcm_s10 <= mul32(pc_s9, PRESS_SCALE);
  end

  // stage 11: operand preparation for the divider
  logic               post2;
  logic signed [31:0] num;
  logic [31:0]        nmag;
  logic [16:0]        dmag;

  always_comb begin
    post2 = (pcm_s10 >= PRESS_OVF);
    num   = post2 ? pcm_s10 : (pcm_s10 <<< 1);
    nmag  = num[31] ? 32'(-num) : 32'(num);
    dmag  = dv_s10[16] ? 17'(-dv_s10) : 17'(dv_s10);
  end

  // restoring divider, one quotient bit per stage
  logic [31:0] d_num [0:DIV_STAGES];
  logic [16:0] d_rem [0:DIV_STAGES];
  logic [16:0] d_dm  [0:DIV_STAGES];
  logic        d_neg [0:DIV_STAGES];
  logic        d_pst [0:DIV_STAGES];
  logic        d_flt [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    d_num[0] <= nmag;
    d_rem[0] <= '0;
    d_dm[0]  <= dmag;
    d_neg[0] <= num[31] ^ dv_s10[16];
    d_pst[0] <= post2;
    d_flt[0] <= (dv_s10 == 17'sd0);
    for (int k = 1; k <= DIV_STAGES; k++) begin
      {d_rem[k], d_num[k]} <= div_step(d_rem[k-1], d_num[k-1], d_dm[k-1]);
      d_dm[k]  <= d_dm[k-1];
      d_neg[k] <= d_neg[k-1];
      d_pst[k] <= d_pst[k-1];
      d_flt[k] <= d_flt[k-1];
    end
  end

  // quotient sign and post-scale, then cubic correction stages
  logic signed [31:0] qt;
  logic signed [31:0] pc_d1, pc_e1, pc_e2, pc_e3, pc_e4;
  logic               f_d1, f_e1, f_e2, f_e3, f_e4;
  logic signed [31:0] rr_e1, q8_e1, qq_e1, m8_e1;
  logic signed [31:0] a9_e2, qqq_e2, b8_e2;
  logic signed [31:0] a_e3, c0_e3, b8_e3;
  logic signed [31:0] sq_e4;

  assign qt = d_neg[DIV_STAGES] ? $signed(-d_num[DIV_STAGES]) : $signed(d_num[DIV_STAGES]);

  always_ff @(posedge clk) begin
    pc_d1  <= d_pst[DIV_STAGES] ? (qt <<< 1) : qt;
    f_d1   <= d_flt[DIV_STAGES];
    rr_e1  <= mul32(pc_d1 >>> 3, pc_d1 >>> 3);
    q8_e1  <= pc_d1 >>> 8;
    qq_e1  <= mul32(pc_d1 >>> 8, pc_d1 >>> 8);
    m8_e1  <= mul32(pc_d1 >>> 2, 32'(p8));
    pc_e1  <= pc_d1;
    f_e1   <= f_d1;
    a9_e2  <= mul32(32'(p9), rr_e1 >>> 13);
    qqq_e2 <= mul32(qq_e1, q8_e1);
    b8_e2  <= m8_e1 >>> 13;
    pc_e2  <= pc_e1;
    f_e2   <= f_e1;
    a_e3   <= a9_e2 >>> 12;
    c0_e3  <= mul32(qqq_e2, $signed({24'h000000, p10}));
    b8_e3  <= b8_e2;
    pc_e3  <= pc_e2;
    f_e3   <= f_e2;
    sq_e4  <= a_e3 + b8_e3 + (c0_e3 >>> 17) + (32'(p7) <<< 7);
    pc_e4  <= pc_e3;
    f_e4   <= f_e3;
  end

  // output stage: final add, saturation, zero divisor
  logic signed [31:0] pc_fin;

  assign pc_fin = pc_e4 + (sq_e4 >>> 4);

  always_ff @(posedge clk) begin
    div_fault <= f_e4;
    if (f_e4 || pc_fin < 32'sd0) begin
      pressure_pa <= '0;
    end else if (pc_fin > PRESS_MAX) begin
      pressure_pa <= PRESS_MAX[17:0];
    end else begin
      pressure_pa <= pc_fin[17:0];
    end
  end

endmodule

// ===== rtl/tpc_checker.sv =====
// ---------------------------------------------------------------------------
// tpc_checker
// port-level checks on request and result timing of the compensation block
// ---------------------------------------------------------------------------
`include "temp_pressure_compensation_macros.svh"

module tpc_checker
  import tpc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [17:0] pressure_pa,
  input logic        div_fault
);

  // every accepted request yields a result after the fixed latency
  `TPC_ASSERT_IMP(a_req_to_done, clk, rst, start && !busy, ##LATENCY done, "request lost")

  // no result without a request the fixed latency earlier
  `TPC_ASSERT_IMP(a_done_from_req, clk, rst, done, $past(start && !busy, LATENCY), "spurious result")

  // a zero divisor forces the pressure to zero
  `TPC_ASSERT_IMP(a_fault_zero, clk, rst, done && div_fault, pressure_pa == 18'd0, "fault pressure")

  // the block never holds off a request
  `TPC_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy, "busy raised")

endmodule

bind temp_pressure_compensation tpc_checker u_tpc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .pressure_pa (pressure_pa),
  .div_fault   (div_fault)
);

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// temp/pressure compensation testbench
// drives raw temperature and pressure readings through the compensation
// pipeline under several calibration sets, predicts each result in
// integer arithmetic and checks every result strobe field by field
// ---------------------------------------------------------------------------
module testbench
  import tpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [19:0] traw;
    logic [19:0] praw;
  } reading_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [17:0]        press;
    logic               fault;
  } compensated_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_addr = REG_TEMP_COEFFS;
  logic [63:0]        cfg_wdata = '0;
  logic               start = 1'b0;
  logic               busy;
  logic [19:0]        temp_raw = '0;
  logic [19:0]        press_raw = '0;
  logic               done;
  logic signed [15:0] temp_centi;
  logic [17:0]        pressure_pa;
  logic               div_fault;

  // calibration copy used by the predictor
  logic [39:0] cal_temp = '0;
  logic [63:0] cal_wide = '0;
  logic [63:0] cal_narrow = '0;

  reading_t     readings_q[$];
  compensated_t expected_q[$];
  bit           req_taken = 1'b0;
  int           gap = 0;
  bit           burst = 1'b0;
  int           n_err = 0;
  int           n_req = 0;
  int           n_fault = 0;
  int           n_temp_sat = 0;
  int           n_press_sat = 0;
  int           idle_cycles = 0;

  temp_pressure_compensation u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .temp_raw(temp_raw), .press_raw(press_raw),
    .done(done), .temp_centi(temp_centi), .pressure_pa(pressure_pa),
    .div_fault(div_fault)
  );

  always #10 clk = ~clk;

  // wrap to a 32-bit two's complement value
  function automatic longint wrap32(input longint v);
    return longint'(signed'(v[31:0]));
  endfunction

  // integer compensation of one reading pair under the current calibration
  function automatic compensated_t compensate(input reading_t rd);
    longint traw, praw, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
    longint a, b, c, q, sq, r, tfine, temp, pc;
    compensated_t res;
    traw = longint'(rd.traw);
    praw = longint'(rd.praw);
    t1 = longint'(cal_temp[15:0]);
    t2 = longint'(signed'(cal_temp[31:16]));
    t3 = longint'(signed'(cal_temp[39:32]));
    p1 = longint'(cal_wide[15:0]);
    p2 = longint'(signed'(cal_wide[31:16]));
    p4 = longint'(signed'(cal_wide[47:32]));
    p5 = longint'(signed'(cal_wide[63:48]));
    p3 = longint'(signed'(cal_narrow[7:0]));
    p6 = longint'(signed'(cal_narrow[15:8]));
    p7 = longint'(signed'(cal_narrow[23:16]));
    p8 = longint'(signed'(cal_narrow[39:24]));
    p9 = longint'(signed'(cal_narrow[55:40]));
    p10 = longint'(cal_narrow[63:56]);
    res.fault = 1'b0;

    // fine temperature and saturated centi-degrees
    a = (traw >>> 3) - t1 * 2;
    b = (a * t2) >>> 11;
    c = ((a >>> 1) * (a >>> 1)) >>> 12;
    c = (c * (t3 * 16)) >>> 14;
    tfine = wrap32(b + c);
    temp = (tfine * 5 + 128) >>> 8;
    if (temp > 32767) temp = 32767;
    if (temp < -32768) temp = -32768;
    res.temp = temp[15:0];

    // divisor and dividend, all 32-bit wrapping
    a = wrap32((tfine >>> 1) - 64000);
    q = a >>> 2;
    sq = wrap32(q * q);
    b = wrap32(wrap32((sq >>> 11) * p6) >>> 2);
    b = wrap32(b + wrap32(wrap32(a * p5) * 2));
    b = wrap32((b >>> 2) + wrap32(p4 * 65536));
    a = wrap32((wrap32((sq >>> 13) * wrap32(p3 * 32)) >>> 3) + (wrap32(p2 * a) >>> 1));
    a = a >>> 18;
    a = wrap32(wrap32(32768 + a) * p1) >>> 15;
    pc = wrap32(1048576 - praw);
    pc = wrap32(wrap32(pc - (b >>> 12)) * 3125);
    if (a == 0) begin
      pc = 0;
      res.fault = 1'b1;
    end else begin
      // divide, then cubic correction
      if (pc >= (64'sd1 << 30)) pc = wrap32(wrap32(pc / a) * 2);
      else pc = wrap32(wrap32(pc * 2) / a);
      r = pc >>> 3;
      a = wrap32(p9 * (wrap32(r * r) >>> 13)) >>> 12;
      b = wrap32((pc >>> 2) * p8) >>> 13;
      q = pc >>> 8;
      c = wrap32(wrap32(wrap32(q * q) * q) * p10) >>> 17;
      sq = wrap32(wrap32(wrap32(a + b) + c) + wrap32(p7 * 128));
      pc = wrap32(pc + (sq >>> 4));
      if (pc < 0) pc = 0;
      if (pc > 262143) pc = 262143;
    end
    res.press = pc[17:0];
    return res;
  endfunction

  // request driver, inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      start <= 1'b1;
    end else if (gap > 0) begin
      start <= 1'b0;
      gap = gap - 1;
    end else if (readings_q.size() > 0) begin
      reading_t rd;
      rd = readings_q.pop_front();
      temp_raw <= rd.traw;
      press_raw <= rd.praw;
      start <= 1'b1;
      if ($urandom_range(0, 49) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 14);
    end else begin
      start <= 1'b0;
    end
  end

  // request capture and prediction
  always @(posedge clk) begin
    req_taken = !rst && start && !busy;
    if (req_taken) begin
      reading_t rd;
      compensated_t res;
      rd.traw = temp_raw;
      rd.praw = press_raw;
      res = compensate(rd);
      expected_q.push_back(res);
      n_req++;
      if (res.fault) n_fault++;
      if (res.temp == 16'sh7fff || res.temp == -16'sh8000) n_temp_sat++;
      if (!res.fault && (res.press == 0 || res.press == 18'h3ffff)) n_press_sat++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: temp %0d press %0d fault %0b",
               temp_centi, pressure_pa, div_fault);
        n_err++;
      end else begin
        compensated_t exp_res;
        exp_res = expected_q.pop_front();
        if (temp_centi !== exp_res.temp) begin
          $error("temp_centi expected %0d actual %0d", exp_res.temp, temp_centi);
          n_err++;
        end
        if (pressure_pa !== exp_res.press) begin
          $error("pressure_pa expected %0d actual %0d", exp_res.press, pressure_pa);
          n_err++;
        end
        if (div_fault !== exp_res.fault) begin
          $error("div_fault expected %0b actual %0b", exp_res.fault, div_fault);
          n_err++;
        end
      end
    end
  end

  // watchdog on cycles without any request or result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (readings_q.size() == 0 && expected_q.size() == 0 && !start);
    repeat (3) @(posedge clk);
  endtask

  // register write on the falling edge, predictor copy follows
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TEMP_COEFFS:  cal_temp = data[39:0];
      REG_PRESS_WIDE:   cal_wide = data;
      REG_PRESS_NARROW: cal_narrow = data;
      default: ;
    endcase
  endtask

  task automatic load_cal(input logic [63:0] tc, input logic [63:0] pw, input logic [63:0] pn);
    wait_idle();
    write_reg(REG_TEMP_COEFFS, tc);
    write_reg(REG_PRESS_WIDE, pw);
    write_reg(REG_PRESS_NARROW, pn);
  endtask

  // with plausible set, mostly plausible readings, the rest anywhere in range
  task automatic queue_readings(input int count, input bit plausible);
    reading_t rd;
    for (int i = 0; i < count; i++) begin
      if (plausible && $urandom_range(0, 3) != 0) begin
        rd.traw = 20'($urandom_range(400000, 600000));
        rd.praw = 20'($urandom_range(200000, 500000));
      end else begin
        rd.traw = 20'($urandom);
        rd.praw = 20'($urandom);
      end
      readings_q.push_back(rd);
    end
  endtask

  task automatic queue_corners();
    reading_t rd;
    logic [19:0] vals[4];
    vals = '{20'h00000, 20'hfffff, 20'h80000, 20'h7ffff};
    foreach (vals[i]) begin
      foreach (vals[j]) begin
        rd.traw = vals[i];
        rd.praw = vals[j];
        readings_q.push_back(rd);
      end
    end
  endtask

  initial begin
    logic [63:0] typ_temp, typ_wide, typ_narrow;
    // typical calibration: t1 27504, t2 26435, t3 -8 / p1 36477 p2 -10685 p4 2855
    // p5 140 / p3 3 p6 -7 p7 15 p8 15500 p9 -14600 p10 6
    typ_temp = {24'h0, 8'hf8, 16'h6743, 16'h6b70};
    typ_wide = {16'h008c, 16'h0b27, 16'hd643, 16'h8e7d};
    typ_narrow = {8'h06, 16'hc6f8, 16'h3c8c, 8'h0f, 8'hf9, 8'h03};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset calibration: zero divisor on every request
    queue_corners();
    queue_readings(120, 1'b0);

    // typical calibration with corners, then a write to an unused index
    load_cal(typ_temp, typ_wide, typ_narrow);
    write_reg(2'd3, 64'($urandom) << 32 | 64'($urandom));
    queue_corners();
    queue_readings(400, 1'b1);

    // all ones, most-negative and most-positive calibration extremes
    load_cal('1, '1, '1);
    queue_readings(150, 1'b0);
    load_cal(64'h80_8000_0000, 64'h8000_8000_8000_0000, 64'h00_8000_8000_80_80_80);
    queue_readings(150, 1'b0);
    load_cal(64'h7f_7fff_ffff, 64'h7fff_7fff_7fff_ffff, 64'hff_7fff_7fff_7f_7f_7f);
    queue_readings(150, 1'b0);

    // typical calibration with small random perturbations
    for (int k = 0; k < 3; k++) begin
      load_cal(typ_temp ^ 64'($urandom_range(0, 255)), typ_wide ^ 64'($urandom_range(0, 255)),
               typ_narrow ^ 64'($urandom_range(0, 255)));
      queue_readings(150, 1'b1);
    end

    // fully random calibration sets
    for (int k = 0; k < 3; k++) begin
      load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      queue_readings(90, 1'b0);
    end

    wait_idle();
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d requests over 11 calibration sets: %0d zero divisor, %0d temp saturated,",
             n_req, n_fault, n_temp_sat);
    $display("%0d pressure clamped, %0d mismatches", n_press_sat, n_err);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
